[hdl/slip_frame_decoder_defines.svh]
// Assertion macros for the SLIP frame decoder
`ifndef SLIP_FRAME_DECODER_DEFINES_SVH
`define SLIP_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTH

`define SFD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define SFD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SFD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define SFD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[hdl/slipd_pkg.sv]
package slipd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    localparam logic [BYTE_W-1:0] CODE_END     = 8'hC0;
    localparam logic [BYTE_W-1:0] CODE_ESC     = 8'hDB;
    localparam logic [BYTE_W-1:0] CODE_ESC_END = 8'hDC;
    localparam logic [BYTE_W-1:0] CODE_ESC_ESC = 8'hDD;

    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_END   = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] data;
    } cmd_t;

endpackage

[hdl/slipd_front.sv]
module slipd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [slipd_pkg::BYTE_W-1:0]  s_tdata,
    output logic                          push_valid,
    input  logic                          push_ready,
    output slipd_pkg::cmd_t               push_cmd
);
    import slipd_pkg::*;

    logic esc_reg, esc_next;
    logic has_data_reg, has_data_next;
    logic accept;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && push_ready;

    always_comb begin
        esc_next      = esc_reg;
        has_data_next = has_data_reg;
        push_valid    = 1'b0;
        push_cmd.kind = CMD_STORE;
        push_cmd.data = s_tdata;
        if (accept) begin
            if (s_tdata == CODE_END) begin
                // end on an empty frame is a no-op
                if (has_data_reg) begin
                    push_valid    = 1'b1;
                    push_cmd.kind = CMD_END;
                    esc_next      = 1'b0;
                    has_data_next = 1'b0;
                end
            end else if (s_tdata == CODE_ESC) begin
                esc_next = 1'b1;
            end else begin
                push_valid    = 1'b1;
                esc_next      = 1'b0;
                has_data_next = 1'b1;
                if (esc_reg && s_tdata == CODE_ESC_END) begin
                    push_cmd.data = CODE_END;
                end else if (esc_reg && s_tdata == CODE_ESC_ESC) begin
                    push_cmd.data = CODE_ESC;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg      <= 1'b0;
            has_data_reg <= 1'b0;
        end else begin
            esc_reg      <= esc_next;
            has_data_reg <= has_data_next;
        end
    end

endmodule

[hdl/slipd_queue.sv]
module slipd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  slipd_pkg::cmd_t push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output slipd_pkg::cmd_t pop_cmd
);
    import slipd_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/slipd_back.sv]
module slipd_back #(
    parameter int MAX_FRAME = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  slipd_pkg::cmd_t              pop_cmd,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,
    output logic                         m_tlast
);
    import slipd_pkg::*;

    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int FW = $clog2(MAX_FRAME + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [BYTE_W-1:0] store_mem [MAX_FRAME];
    logic [FW-1:0]     fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic [FW-1:0]     len_reg, len_next;
    logic              frame_ovf_reg, frame_ovf_next;
    logic [FW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_last_reg, rd_last_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic [FW-1:0]     out_len_reg;
    logic              out_ovf_reg;
    logic              do_pop, do_write, do_read, is_last_rd, out_take;

    assign pop_ready  = (state_reg == ST_IDLE);
    assign do_pop     = pop_valid && pop_ready;
    assign do_write   = do_pop && pop_cmd.kind == CMD_STORE && fill_reg < FW'(MAX_FRAME);
    assign out_take   = out_valid_reg && m_tready;
    assign do_read    = (state_reg == ST_DRAIN) && !rd_valid_reg
                        && (!out_valid_reg || m_tready);
    assign is_last_rd = (rd_cnt_reg == len_reg - FW'(1));

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        len_next       = len_reg;
        frame_ovf_next = frame_ovf_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_valid_next  = do_read;
        rd_last_next   = rd_last_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (do_pop) begin
                    if (pop_cmd.kind == CMD_END) begin
                        len_next       = fill_reg;
                        frame_ovf_next = ovf_reg;
                        fill_next      = '0;
                        ovf_next       = 1'b0;
                        rd_cnt_next    = '0;
                        state_next     = ST_DRAIN;
                    end else if (do_write) begin
                        fill_next = fill_reg + FW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (do_read) begin
                    rd_last_next = is_last_rd;
                    rd_cnt_next  = rd_cnt_reg + FW'(1);
                    if (is_last_rd) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (rd_valid_reg) begin
            out_valid_next = 1'b1;
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            store_mem[fill_reg[AW-1:0]] <= pop_cmd.data;
        end
        if (do_read) begin
            rd_data_reg <= store_mem[rd_cnt_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            out_byte_reg <= rd_data_reg;
            out_last_reg <= rd_last_reg;
            out_len_reg  <= len_reg;
            out_ovf_reg  <= frame_ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            len_reg       <= '0;
            frame_ovf_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            len_reg       <= len_next;
            frame_ovf_reg <= frame_ovf_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_ovf_reg, LEN_W'(out_len_reg), out_byte_reg};

`include "slip_frame_decoder_defines.svh"

    `SFD_ASSERT_IMP(a_rd_into_free_out, aclk, aresetn, rd_valid_reg, !out_valid_reg, "read data would overwrite a held transfer")
    `SFD_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FW'(MAX_FRAME), "fill count above capacity")
    `SFD_ASSERT_IMP(a_drain_nonempty, aclk, aresetn, state_reg == ST_DRAIN, len_reg != '0 && rd_cnt_reg < len_reg, "drain with empty frame or past its end")

endmodule

[hdl/slip_frame_decoder.sv]
// Flow: a stored byte passes through the queue and is written to the frame store while no
// frame is draining; after the END byte, each result passes the store read register and then
// the output register. Throughput: 1 input byte per cycle while the 2-entry queue has room;
// a new store read starts only once the previous one has moved on to the output register.
// Reset: synchronous active-low aresetn clears escape, fill count, overflow, queue and
// output valid; frame store contents are not cleared.
module slip_frame_decoder #(
    parameter int MAX_FRAME = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] frame_byte, [14:8] frame_length, [15] overflowed
    output logic        m_tlast    // last_of_frame
);
    import slipd_pkg::*;

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    slipd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    slipd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    slipd_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slipd_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int MAX_FRAME  = 64;
    localparam int RAND_ITEMS = 230;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN      = 60;
    localparam int N_DIR      = 37;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [LEN_W-1:0]  len;
        logic              ovf;
    } frame_beat_t;

    // typed rows: frame of t_len copies of t_byte
    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic [7:0]        reps;
        logic              typed;
        logic [BYTE_W-1:0] t_byte;
        logic [LEN_W-1:0]  t_len;
        logic              t_ovf;
    } dir_row_t;

    dir_row_t dir_tab [N_DIR] = '{
        '{CODE_END,     8'd1,  1'b0, 8'h00,    7'd0,  1'b0},  // end on empty frame
        '{8'h00,        8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_END,     8'd1,  1'b1, 8'h00,    7'd1,  1'b0},
        '{8'hFF,        8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_END,     8'd1,  1'b1, 8'hFF,    7'd1,  1'b0},
        '{CODE_ESC,     8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_ESC_END, 8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_END,     8'd1,  1'b1, CODE_END, 7'd1,  1'b0},
        '{CODE_ESC,     8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_ESC_ESC, 8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_END,     8'd1,  1'b1, CODE_ESC, 7'd1,  1'b0},
        '{CODE_ESC,     8'd1,  1'b0, 8'h00,    7'd0,  1'b0},  // escape after escape
        '{CODE_ESC,     8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_ESC_ESC, 8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_END,     8'd1,  1'b1, CODE_ESC, 7'd1,  1'b0},
        '{CODE_ESC,     8'd1,  1'b0, 8'h00,    7'd0,  1'b0},  // escape before other byte
        '{8'h41,        8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_END,     8'd1,  1'b1, 8'h41,    7'd1,  1'b0},
        '{CODE_ESC_END, 8'd1,  1'b0, 8'h00,    7'd0,  1'b0},  // unescaped codes stored raw
        '{CODE_ESC_ESC, 8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_END,     8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{8'h12,        8'd1,  1'b0, 8'h00,    7'd0,  1'b0},  // end after escape
        '{CODE_ESC,     8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_END,     8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_ESC_END, 8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_END,     8'd1,  1'b1, CODE_ESC_END, 7'd1, 1'b0},
        '{CODE_ESC,     8'd1,  1'b0, 8'h00,    7'd0,  1'b0},  // escape kept over empty end
        '{CODE_END,     8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_ESC_END, 8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_END,     8'd1,  1'b1, CODE_END, 7'd1,  1'b0},
        '{8'h55,        8'd70, 1'b0, 8'h00,    7'd0,  1'b0},  // full store
        '{CODE_ESC,     8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_ESC_END, 8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_ESC_ESC, 8'd1,  1'b0, 8'h00,    7'd0,  1'b0},
        '{CODE_END,     8'd1,  1'b1, 8'h55,    7'd64, 1'b1},
        '{8'hAA,        8'd64, 1'b0, 8'h00,    7'd0,  1'b0},  // exactly full
        '{CODE_END,     8'd1,  1'b1, 8'hAA,    7'd64, 1'b0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // sideband that travels with the driven byte
    logic              row_typed = 1'b0;
    logic [BYTE_W-1:0] row_byte  = '0;
    logic [LEN_W-1:0]  row_len   = '0;
    logic              row_ovf   = 1'b0;

    // decoder model state
    logic [BYTE_W-1:0] rx_store [MAX_FRAME];
    int                rx_fill = 0;
    logic              rx_esc  = 1'b0;
    logic              rx_ovf  = 1'b0;

    frame_beat_t new_beats [$];
    frame_beat_t frame_beats_due [$];

    int items_sent    = 0;
    int burst_left    = 0;
    int frames_seen   = 0;
    int ovf_frames    = 0;
    int beats_checked = 0;
    int mism_count    = 0;
    int idle_cycles   = 0;
    int rdy_mode      = 0;
    int rdy_left      = 0;
    logic [4:0] rdy_phase = '0;

    slip_frame_decoder #(
        .MAX_FRAME(MAX_FRAME)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic store_decoded(input logic [BYTE_W-1:0] v);
        if (rx_fill < MAX_FRAME) begin
            rx_store[rx_fill] = v;
            rx_fill++;
        end else begin
            rx_ovf = 1'b1;
        end
        rx_esc = 1'b0;
    endtask

    task automatic decode_rx_byte(input logic [BYTE_W-1:0] b);
        frame_beat_t beat;
        new_beats.delete();
        if (b == CODE_END) begin
            if (rx_fill != 0) begin
                for (int k = 0; k < rx_fill; k++) begin
                    beat.data = rx_store[k];
                    beat.last = (k == rx_fill - 1);
                    beat.len  = LEN_W'(rx_fill);
                    beat.ovf  = rx_ovf;
                    new_beats.push_back(beat);
                end
                frames_seen++;
                if (rx_ovf)
                    ovf_frames++;
                rx_fill = 0;
                rx_esc  = 1'b0;
                rx_ovf  = 1'b0;
            end
        end else if (b == CODE_ESC) begin
            rx_esc = 1'b1;
        end else if (rx_esc && b == CODE_ESC_END) begin
            store_decoded(CODE_END);
        end else if (rx_esc && b == CODE_ESC_ESC) begin
            store_decoded(CODE_ESC);
        end else begin
            store_decoded(b);
        end
    endtask

    // result check first, then predict from the byte taken at this edge
    always @(posedge aclk) begin
        frame_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_checked++;
            if (frame_beats_due.size() == 0) begin
                mism_count++;
                if (mism_count <= 10)
                    $display("unexpected result: byte %h last %b len %0d ovf %b",
                             m_tdata[7:0], m_tlast, m_tdata[14:8], m_tdata[15]);
            end else begin
                want = frame_beats_due.pop_front();
                if (want.data !== m_tdata[7:0] || want.last !== m_tlast ||
                    want.len !== m_tdata[14:8] || want.ovf !== m_tdata[15]) begin
                    mism_count++;
                    if (mism_count <= 10)
                        $display({"mismatch at %0t: exp byte %h last %b len %0d ovf %b,",
                                  " got byte %h last %b len %0d ovf %b"},
                                 $realtime, want.data, want.last, want.len, want.ovf,
                                 m_tdata[7:0], m_tlast, m_tdata[14:8], m_tdata[15]);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            decode_rx_byte(s_tdata);
            if (row_typed) begin
                for (int k = 0; k < row_len; k++) begin
                    want.data = row_byte;
                    want.last = (k == row_len - 1);
                    want.len  = row_len;
                    want.ovf  = row_ovf;
                    frame_beats_due.push_back(want);
                end
            end else begin
                foreach (new_beats[k])
                    frame_beats_due.push_back(new_beats[k]);
            end
        end
    end

    // receiver: switches between randomly chosen stall modes
    always @(posedge aclk) begin
        rdy_phase <= rdy_phase + 1'b1;
        if (rdy_left == 0) begin
            rdy_mode <= $urandom_range(0, 3);
            rdy_left <= $urandom_range(32, 256);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (rdy_phase == '0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_rx(input logic [BYTE_W-1:0] b, input logic typed,
                           input logic [BYTE_W-1:0] t_byte, input logic [LEN_W-1:0] t_len,
                           input logic t_ovf);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid  <= 1'b1;
        s_tdata   <= b;
        row_typed <= typed;
        row_byte  <= t_byte;
        row_len   <= t_len;
        row_ovf   <= t_ovf;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_plain(input logic [BYTE_W-1:0] b);
        send_rx(b, 1'b0, '0, '0, 1'b0);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 3) != 0)
            return BYTE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: return CODE_END;
            1: return CODE_ESC;
            2: return CODE_ESC_END;
            default: return CODE_ESC_ESC;
        endcase
    endfunction

    initial begin
        int dir_items;
        int n;
        int lost;
        logic [BYTE_W-1:0] v;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            for (int j = 0; j < dir_tab[i].reps; j++)
                send_rx(dir_tab[i].rx, dir_tab[i].typed && (j == dir_tab[i].reps - 1),
                        dir_tab[i].t_byte, dir_tab[i].t_len, dir_tab[i].t_ovf);
        dir_items = items_sent;

        // mostly well-formed frames, some raw noise and broken escapes
        while (items_sent - dir_items < RAND_ITEMS) begin
            if ($urandom_range(0, 99) < 75) begin
                if ($urandom_range(0, 6) == 0)
                    send_plain(CODE_END);
                n = ($urandom_range(0, 11) == 0) ? $urandom_range(56, 72)
                                                  : $urandom_range(1, 16);
                for (int k = 0; k < n; k++) begin
                    v = pick_byte();
                    if (v == CODE_END) begin
                        send_plain(CODE_ESC);
                        send_plain(CODE_ESC_END);
                    end else if (v == CODE_ESC) begin
                        send_plain(CODE_ESC);
                        send_plain(CODE_ESC_ESC);
                    end else begin
                        send_plain(v);
                    end
                end
                send_plain(CODE_END);
            end else begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    send_plain(pick_byte());
            end
        end
        send_plain(CODE_END);
        s_tvalid <= 1'b0;

        while (frame_beats_due.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        lost = frame_beats_due.size();
        $display("input transfers %0d, frames %0d (%0d with dropped bytes), results checked %0d",
                 items_sent, frames_seen, ovf_frames, beats_checked);
        $display("mismatches %0d, results never seen %0d", mism_count, lost);
        if (mism_count == 0 && lost == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
